// ===== rtl/tdm_pkg.sv =====
// Shared constants, register codes, types and the divide-by-100 helper of the tank drive mixer.
`default_nettype none

package tdm_pkg;

	localparam int WIDTH_BITS_DEF = 12;
	localparam int CFG_ADDR_BITS = 5;
	localparam int CFG_DATA_BITS = 32;
	localparam int PCT_BITS = 7;
	localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

	// Quotient bits of the saturating divider and how they spread over its stages.
	localparam int QDIV_BITS = PCT_BITS + 1;
	localparam int QDIV_STEPS = 2;
	localparam int QDIV_STAGES = QDIV_BITS / QDIV_STEPS;

	// Reciprocal of 100 in 32 fraction bits; exact for every input below 2**30.
	localparam int DIV_IN_BITS = 30;
	localparam int DIV_SHIFT = 32;
	localparam logic [25:0] DIV_K = 26'd42949673;

	localparam int CENTER_RST = 1500;
	localparam int MIN_RST = 1000;
	localparam int MAX_RST = 2000;
	localparam int REV_PCT_RST = 100;
	localparam int DEAD_ZONE_RST = 20;

	typedef enum logic [2:0] {
		REG_CENTER,
		REG_MIN,
		REG_MAX,
		REG_REV_PCT,
		REG_DEAD_ZONE
	} cfg_reg_t;

	// Side information that travels with a divider operand pair.
	typedef struct packed {
		logic neg;   // quotient would be negative
		logic one;   // no scaling needed, result is full percent
	} qdiv_ctl_t;

	function automatic logic [DIV_IN_BITS-1:0] div100(input logic [DIV_IN_BITS-1:0] x);
		logic [DIV_IN_BITS+25:0] prod;
		prod = (DIV_IN_BITS + 26)'(x) * (DIV_IN_BITS + 26)'(DIV_K);
		return prod[DIV_SHIFT +: DIV_IN_BITS];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tdm_if.sv =====
// Valid/ready channel interfaces for command items and track items.
`default_nettype none

interface tdm_cmd_if #(parameter int W = 12);
	logic valid;
	logic ready;
	logic [W-1:0] throttle_width;
	logic [W-1:0] steer_width;
	modport source(output valid, output throttle_width, output steer_width, input ready);
	modport sink(input valid, input throttle_width, input steer_width, output ready);
endinterface

interface tdm_trk_if #(parameter int W = 12);
	logic valid;
	logic ready;
	logic [W-1:0] left_width;
	logic [W-1:0] right_width;
	modport source(output valid, output left_width, output right_width, input ready);
	modport sink(input valid, input left_width, input right_width, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdm_cfg.sv =====
// APB register file holding the mixer configuration.
`default_nettype none

module tdm_cfg import tdm_pkg::*; #(
	parameter int W = WIDTH_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic pready,
	output logic [W-1:0] center,
	output logic [W-1:0] min_w,
	output logic [W-1:0] max_w,
	output logic [7:0] rev_pct,
	output logic [W-1:0] dead_zone
);

	logic [W-1:0] center_q, min_q, max_q, dz_q;
	logic [7:0] rev_pct_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= W'(CENTER_RST);
			min_q <= W'(MIN_RST);
			max_q <= W'(MAX_RST);
			rev_pct_q <= 8'(REV_PCT_RST);
			dz_q <= W'(DEAD_ZONE_RST);
		end else if (wr) begin
			case (cfg_reg_t'(paddr[4:2]))
				REG_CENTER: center_q <= pwdata[W-1:0];
				REG_MIN: min_q <= pwdata[W-1:0];
				REG_MAX: max_q <= pwdata[W-1:0];
				REG_REV_PCT: rev_pct_q <= pwdata[7:0];
				REG_DEAD_ZONE: dz_q <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[4:2]))
			REG_CENTER: prdata = CFG_DATA_BITS'(center_q);
			REG_MIN: prdata = CFG_DATA_BITS'(min_q);
			REG_MAX: prdata = CFG_DATA_BITS'(max_q);
			REG_REV_PCT: prdata = CFG_DATA_BITS'(rev_pct_q);
			REG_DEAD_ZONE: prdata = CFG_DATA_BITS'(dz_q);
			default: prdata = '0;
		endcase
	end

	assign center = center_q;
	assign min_w = min_q;
	assign max_w = max_q;
	assign rev_pct = rev_pct_q;
	assign dead_zone = dz_q;

endmodule

`default_nettype wire

// ===== rtl/tdm_qdiv.sv =====
// Pipelined restoring divider giving a percentage saturated to 0..100.
`default_nettype none

module tdm_qdiv import tdm_pkg::*; #(
	parameter int NW = 19,
	parameter int DW = 15
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire qdiv_ctl_t ctl,
	output logic [PCT_BITS-1:0] pct
);

	localparam int RW = (NW > DW + QDIV_BITS) ? NW : DW + QDIV_BITS;

	logic [RW-1:0] rem_s [QDIV_STAGES+1];
	logic [QDIV_BITS-1:0] quo_s [QDIV_STAGES+1];
	logic [DW-1:0] den_s [QDIV_STAGES+1];
	qdiv_ctl_t ctl_s [QDIV_STAGES+1];
	logic [QDIV_BITS-1:0] q_fin;

	assign rem_s[0] = RW'(num);
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign ctl_s[0] = ctl;

	// Each stage retires two quotient bits, most significant first.
	for (genvar g = 0; g < QDIV_STAGES; g++) begin : g_stage
		logic [RW-1:0] r_nx;
		logic [QDIV_BITS-1:0] q_nx;
		logic [RW-1:0] dsh;

		always_comb begin
			r_nx = rem_s[g];
			q_nx = quo_s[g];
			dsh = '0;
			for (int j = 0; j < QDIV_STEPS; j++) begin
				dsh = RW'(den_s[g]) << (QDIV_BITS - 1 - QDIV_STEPS * g - j);
				if (r_nx >= dsh) begin
					r_nx = r_nx - dsh;
					q_nx[QDIV_BITS - 1 - QDIV_STEPS * g - j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= r_nx;
				quo_s[g+1] <= q_nx;
				den_s[g+1] <= den_s[g];
				ctl_s[g+1] <= ctl_s[g];
			end
		end
	end

	// A set top bit means the true quotient is at least 128, so it saturates too.
	assign q_fin = quo_s[QDIV_STAGES];
	always_comb begin
		if (ctl_s[QDIV_STAGES].one) begin
			pct = PCT_FULL;
		end else if (ctl_s[QDIV_STAGES].neg) begin
			pct = '0;
		end else if (q_fin[QDIV_BITS-1] || (q_fin[PCT_BITS-1:0] > PCT_FULL)) begin
			pct = PCT_FULL;
		end else begin
			pct = q_fin[PCT_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tank_drive_mixer_top.sv =====
// Top level of the tank drive mixer: configuration port and the mixing pipeline.
`default_nettype none

// The mixer turns one throttle/steer pulse-width pair into one left/right track
// pulse-width pair. It takes a new item on every clock cycle unless the output
// stalls; the length of its pipeline is set by the two multiply-and-divide-by-100
// steps and the four-stage percentage divider. The whole pipeline advances
// together: when the output item is not taken, every stage holds and the input
// stops accepting until the output moves. Registers sit on an APB port at byte
// addresses 0x0 (center), 0x4 (min), 0x8 (max), 0xC (reverse percent) and 0x10
// (dead zone); they are meant to be written only while no item is in flight. No
// clearing pass is needed after reset.
module tank_drive_mixer_top import tdm_pkg::*; #(
	parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tdm_cmd_if.sink cmd,
	tdm_trk_if.source trk,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic pready
);

	localparam int W = WIDTH_BITS;
	localparam int LW = W + 4;          // signed track offset
	localparam int NW = W + 7;          // bound offset times 100
	localparam int DW = W + 3;          // track offset magnitude
	localparam int PW = W + 10;         // offset magnitude times percent
	localparam int NSTG = 11;

	logic [W-1:0] center, min_w, max_w, dead_zone;
	logic [7:0] rev_pct;

	tdm_cfg #(.W(W)) u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.center(center), .min_w(min_w), .max_w(max_w),
		.rev_pct(rev_pct), .dead_zone(dead_zone)
	);

	// One enable moves every stage; the last stage is the output register.
	logic en;
	logic [NSTG:1] valid_s;

	assign en = !valid_s[NSTG] || trk.ready;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[NSTG-1:1], cmd.valid};
		end
	end

	// Stage 1: inputs within the dead zone of center snap to center.
	logic [W-1:0] thr_s1, str_s1;
	logic signed [W:0] thr_d, str_d;
	logic [W-1:0] thr_ad, str_ad;

	always_comb begin
		thr_d = $signed({1'b0, cmd.throttle_width}) - $signed({1'b0, center});
		str_d = $signed({1'b0, cmd.steer_width}) - $signed({1'b0, center});
		thr_ad = thr_d[W] ? W'(-thr_d) : thr_d[W-1:0];
		str_ad = str_d[W] ? W'(-str_d) : str_d[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			thr_s1 <= (thr_ad <= dead_zone) ? center : cmd.throttle_width;
			str_s1 <= (str_ad <= dead_zone) ? center : cmd.steer_width;
		end
	end

	// Stage 2: a throttle below center is multiplied by the reverse percent.
	logic [W+7:0] thr_prod_s2;
	logic thr_neg_s2;
	logic signed [W:0] str_off_s2;
	logic thr_lt;
	logic [W-1:0] thr_mag;

	always_comb begin
		thr_lt = thr_s1 < center;
		thr_mag = thr_lt ? (center - thr_s1) : (thr_s1 - center);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			thr_prod_s2 <= thr_lt ? ((W + 8)'(thr_mag) * (W + 8)'(rev_pct)) : (W + 8)'(thr_mag);
			thr_neg_s2 <= thr_lt;
			str_off_s2 <= $signed({1'b0, str_s1}) - $signed({1'b0, center});
		end
	end

	// Stage 3: divide the reverse product by 100, truncating toward zero.
	logic signed [W+2:0] thr_off_s3;
	logic signed [W:0] str_off_s3;
	logic [DIV_IN_BITS-1:0] thr_q;
	logic [W+1:0] thr_qm;

	always_comb begin
		thr_q = div100(DIV_IN_BITS'(thr_prod_s2));
		thr_qm = thr_neg_s2 ? thr_q[W+1:0] : thr_prod_s2[W+1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			thr_off_s3 <= thr_neg_s2 ? -$signed({1'b0, thr_qm}) : $signed({1'b0, thr_qm});
			str_off_s3 <= str_off_s2;
		end
	end

	// Stage 4: track offsets, and the divider operands for each track.
	// Side 0 is the left track, side 1 the right track.
	logic signed [LW-1:0] off_s4 [2];
	logic [NW-1:0] num_s4 [2];
	logic [DW-1:0] den_s4 [2];
	qdiv_ctl_t ctl_s4 [2];
	logic signed [W:0] hi_off, lo_off;
	logic signed [LW-1:0] off_c [2];

	always_comb begin
		hi_off = $signed({1'b0, max_w}) - $signed({1'b0, center});
		lo_off = $signed({1'b0, min_w}) - $signed({1'b0, center});
		off_c[0] = LW'(thr_off_s3) + LW'(str_off_s3);
		off_c[1] = LW'(thr_off_s3) - LW'(str_off_s3);
	end

	for (genvar s = 0; s < 2; s++) begin : g_side
		logic over_hi, under_lo;
		logic signed [W:0] bnd;
		logic [W-1:0] bmag;
		logic [DW-1:0] omag;

		always_comb begin
			over_hi = (off_c[s] > LW'(hi_off)) && (off_c[s] != '0);
			under_lo = (off_c[s] < LW'(lo_off)) && (off_c[s] != '0);
			bnd = over_hi ? hi_off : lo_off;
			bmag = bnd[W] ? W'(-bnd) : bnd[W-1:0];
			omag = off_c[s][LW-1] ? DW'(-off_c[s]) : off_c[s][DW-1:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				off_s4[s] <= off_c[s];
				num_s4[s] <= NW'(bmag) * NW'(PCT_FULL);
				den_s4[s] <= omag;
				ctl_s4[s].neg <= bnd[W] ^ off_c[s][LW-1];
				ctl_s4[s].one <= !(over_hi || under_lo);
			end
		end
	end

	// Stages 5 to 8: the percentage dividers, offsets riding alongside.
	logic [PCT_BITS-1:0] pct_d [2];
	logic signed [LW-1:0] off_s5 [2], off_s6 [2], off_s7 [2], off_s8 [2];

	for (genvar s = 0; s < 2; s++) begin : g_div
		tdm_qdiv #(.NW(NW), .DW(DW)) u_qdiv (
			.clk(clk), .en(en),
			.num(num_s4[s]), .den(den_s4[s]), .ctl(ctl_s4[s]),
			.pct(pct_d[s])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				off_s5[s] <= off_s4[s];
				off_s6[s] <= off_s5[s];
				off_s7[s] <= off_s6[s];
				off_s8[s] <= off_s7[s];
			end
		end
	end

	// Stage 9: the smaller percentage scales both offsets.
	logic [PCT_BITS-1:0] pct_min;
	logic [PW-1:0] prod_s9 [2];
	logic neg_s9 [2];

	assign pct_min = (pct_d[1] < pct_d[0]) ? pct_d[1] : pct_d[0];

	for (genvar s = 0; s < 2; s++) begin : g_scale
		logic [DW-1:0] mag;

		assign mag = off_s8[s][LW-1] ? DW'(-off_s8[s]) : off_s8[s][DW-1:0];

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s9[s] <= PW'(mag) * PW'(pct_min);
				neg_s9[s] <= off_s8[s][LW-1];
			end
		end
	end

	// Stage 10: divide by 100; stage 11: add center and clamp to min..max.
	logic signed [LW-1:0] off_s10 [2];
	logic [W-1:0] width_s11 [2];

	for (genvar s = 0; s < 2; s++) begin : g_out
		logic [DIV_IN_BITS-1:0] q;
		logic signed [W+4:0] sum;

		assign q = div100(DIV_IN_BITS'(prod_s9[s]));
		assign sum = $signed({5'b0, center}) + (W + 5)'(off_s10[s]);

		always_ff @(posedge clk) begin
			if (en) begin
				off_s10[s] <= neg_s9[s] ? -$signed({1'b0, q[DW-1:0]}) : $signed({1'b0, q[DW-1:0]});
				if (sum < $signed({5'b0, min_w})) begin
					width_s11[s] <= min_w;
				end else if (sum > $signed({5'b0, max_w})) begin
					width_s11[s] <= max_w;
				end else begin
					width_s11[s] <= sum[W-1:0];
				end
			end
		end
	end

	assign trk.valid = valid_s[NSTG];
	assign trk.left_width = width_s11[0];
	assign trk.right_width = width_s11[1];

	// With a sane window every delivered width lies inside it.
	a_left_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(trk.valid && (min_w <= max_w)) |-> (trk.left_width >= min_w && trk.left_width <= max_w))
		else $error("left width outside min..max");

	a_right_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(trk.valid && (min_w <= max_w)) |-> (trk.right_width >= min_w && trk.right_width <= max_w))
		else $error("right width outside min..max");

	// An accepted item occupies the first stage on the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> valid_s[1])
		else $error("accepted item did not enter the pipeline");

	// The scaling percentage never exceeds full scale.
	a_pct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[8] |-> (pct_min <= PCT_FULL))
		else $error("scaling percentage above 100");

endmodule

`default_nettype wire

// ===== dv/tb_tank_drive_mixer_top.sv =====
// Testbench for the tank drive mixer: directed table, random commands, scoreboard against a predictor.
`timescale 1ns / 1ps

module tb_tank_drive_mixer_top;
	import tdm_pkg::*;

	localparam int W = WIDTH_BITS_DEF;
	localparam int N_RANDOM = 1800;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic pready;

	tdm_cmd_if #(.W(W)) cmd ();
	tdm_trk_if #(.W(W)) trk ();

	tank_drive_mixer_top #(.WIDTH_BITS(W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.trk(trk.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// The predictor's copy of the mixer settings.
	int mix_center;
	int mix_min;
	int mix_max;
	int mix_rev;
	int mix_dead;

	typedef struct {
		logic [W-1:0] left;
		logic [W-1:0] right;
	} tracks_t;

	tracks_t track_queue[$];
	int err_count;
	int cycle_count;
	int checked_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;

	// Directed rows: throttle, steer, and an expected result where one is obvious.
	typedef struct {
		int thr;
		int str;
		bit known;
		int left;
		int right;
	} row_t;

	row_t dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				track_queue.size());
			$display("tb_tank_drive_mixer_top: errors");
			$finish;
		end
	end

	function automatic int snap(int w);
		int d;
		d = w - mix_center;
		if (d < 0) d = -d;
		return (d <= mix_dead) ? mix_center : w;
	endfunction

	// Percentage that brings one offset back inside its bound.
	function automatic int scale_pct(int off, int lo_off, int hi_off);
		if (off > hi_off && off != 0) return (hi_off * 100) / off;
		if (off < lo_off && off != 0) return (lo_off * 100) / off;
		return 100;
	endfunction

	function automatic int clamp_width(int v);
		if (v < mix_min) return mix_min;
		if (v > mix_max) return mix_max;
		return v;
	endfunction

	function automatic tracks_t mix_tracks(int thr_w, int str_w);
		int thr_off;
		int str_off;
		int l_off;
		int r_off;
		int pct;
		int rp;
		tracks_t t;
		thr_off = snap(thr_w) - mix_center;
		// SystemVerilog int division truncates toward zero, as the block does.
		if (thr_off < 0) thr_off = (thr_off * mix_rev) / 100;
		str_off = snap(str_w) - mix_center;
		l_off = thr_off + str_off;
		r_off = thr_off - str_off;
		pct = scale_pct(l_off, mix_min - mix_center, mix_max - mix_center);
		rp = scale_pct(r_off, mix_min - mix_center, mix_max - mix_center);
		if (rp < pct) pct = rp;
		if (pct > 100) pct = 100;
		if (pct < 0) pct = 0;
		l_off = (l_off * pct) / 100;
		r_off = (r_off * pct) / 100;
		t.left = W'(clamp_width(mix_center + l_off));
		t.right = W'(clamp_width(mix_center + r_off));
		return t;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
			want);
	endtask

	// APB write: a setup cycle, then an access cycle; pready is always high.
	// The port is left selected; the caller releases it after the last access.
	task automatic apb_write(input cfg_reg_t r, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_BITS'(4 * int'(r));
		pwdata <= CFG_DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (r)
			REG_CENTER: mix_center = value & 12'hFFF;
			REG_MIN: mix_min = value & 12'hFFF;
			REG_MAX: mix_max = value & 12'hFFF;
			REG_REV_PCT: mix_rev = value & 8'hFF;
			REG_DEAD_ZONE: mix_dead = value & 12'hFFF;
			default: ;
		endcase
	endtask

	// A readback of a written register also exercises the read path of the port.
	task automatic apb_check(input cfg_reg_t r, input int want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CFG_ADDR_BITS'(4 * int'(r));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata != CFG_DATA_BITS'(want)) report_mismatch("register read", prdata, want);
	endtask

	task automatic set_config(input int c, input int lo, input int hi, input int rev,
		input int dz);
		apb_write(REG_CENTER, c);
		apb_write(REG_MIN, lo);
		apb_write(REG_MAX, hi);
		apb_write(REG_REV_PCT, rev);
		apb_write(REG_DEAD_ZONE, dz);
		apb_check(REG_CENTER, mix_center);
		apb_check(REG_REV_PCT, mix_rev);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one command item and hold it until the mixer takes it. The
	// expectation is queued at acceptance, under the settings in force.
	// Valid stays high after acceptance so that items can follow back to back.
	task automatic send_cmd(input int thr, input int str);
		while (($urandom % 100) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.throttle_width <= W'(thr);
		cmd.steer_width <= W'(str);
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		track_queue.push_back(mix_tracks(thr, str));
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		while (track_queue.size() != 0) @(posedge clk);
		// Let the pipeline settle before any write.
		repeat (16) @(posedge clk);
	endtask

	// Random widths: mostly near the configured window so that the scaling is
	// reached often, sometimes on the dead-zone edge, otherwise anywhere in the field.
	function automatic int pick_width();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2) return $urandom_range(0, 4095);
		if (sel == 2) return (mix_center + (($urandom_range(0, 1)) ? mix_dead : -mix_dead))
			& 12'hFFF;
		return (mix_center + $urandom_range(0, 1400) - 700) & 12'hFFF;
	endfunction

	// Receiver: random back-pressure, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk.ready <= 1'b0;
		end else begin
			trk.ready <= !recv_hold && (($urandom % 100) >= recv_idle_pct);
		end
	end

	// Scoreboard: each accepted track item is compared with the oldest expectation.
	always @(posedge clk) begin
		tracks_t want;
		if (arst_n && trk.valid && trk.ready) begin
			if (track_queue.size() == 0) begin
				err_count++;
				$display("unexpected track item at cycle %0d", cycle_count);
			end else begin
				want = track_queue.pop_front();
				checked_count++;
				if (trk.left_width !== want.left)
					report_mismatch("left_width", trk.left_width, want.left);
				if (trk.right_width !== want.right)
					report_mismatch("right_width", trk.right_width, want.right);
			end
		end
	end

	task automatic add_row(input int thr, input int str, input bit known, input int l,
		input int r);
		row_t rw;
		rw.thr = thr;
		rw.str = str;
		rw.known = known;
		rw.left = l;
		rw.right = r;
		dir_rows.push_back(rw);
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			send_cmd(pick_width(), pick_width());
		end
	endtask

	initial begin
		int k;
		cycle_count = 0;
		err_count = 0;
		checked_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd.valid = 1'b0;
		cmd.throttle_width = '0;
		cmd.steer_width = '0;
		mix_center = CENTER_RST;
		mix_min = MIN_RST;
		mix_max = MAX_RST;
		mix_rev = REV_PCT_RST;
		mix_dead = DEAD_ZONE_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings. Center in gives center out;
		// full forward or back is scaled back to just inside the window;
		// pure steer pivots.
		add_row(1500, 1500, 1, 1500, 1500);
		add_row(1520, 1480, 1, 1500, 1500);
		add_row(1521, 1500, 0, 0, 0);
		add_row(4095, 1500, 1, 1993, 1993);
		add_row(0, 1500, 1, 1005, 1005);
		add_row(1500, 4095, 1, 1993, 1007);
		add_row(1500, 0, 1, 1005, 1995);
		add_row(4095, 4095, 0, 0, 0);
		add_row(0, 0, 0, 0, 0);
		add_row(2000, 1700, 0, 0, 0);
		add_row(1200, 1300, 0, 0, 0);
		add_row(2730, 1365, 0, 0, 0);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].known) begin
				tracks_t p;
				p = mix_tracks(dir_rows[i].thr, dir_rows[i].str);
				if (p.left != W'(dir_rows[i].left) || p.right != W'(dir_rows[i].right))
					report_mismatch("table row", i, -1);
			end
			send_cmd(dir_rows[i].thr, dir_rows[i].str);
		end
		drain();

		// Amplified reverse, zero dead zone, inverted bounds, and center at either end.
		set_config(1500, 1000, 2000, 255, 0);
		send_cmd(0, 1500);
		send_cmd(1499, 1501);
		send_cmd(1000, 2000);
		drain();
		set_config(1500, 1800, 1200, 0, 4095);
		send_cmd(0, 4095);
		send_cmd(4095, 0);
		drain();
		set_config(0, 0, 4095, 50, 0);
		send_cmd(4095, 0);
		send_cmd(0, 4095);
		drain();
		set_config(4095, 4095, 0, 100, 7);
		send_cmd(0, 0);
		send_cmd(2048, 4095);
		drain();

		// Random phases under several settings and idling patterns.
		set_config(CENTER_RST, MIN_RST, MAX_RST, REV_PCT_RST, DEAD_ZONE_RST);
		send_idle_pct = 27;
		recv_idle_pct = 62;
		random_phase(N_RANDOM / 3);
		drain();
		set_config(1500, 1100, 1900, 75, 40);
		send_idle_pct = 62;
		recv_idle_pct = 27;
		random_phase(N_RANDOM / 3);
		drain();
		set_config($urandom_range(500, 3500), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 300));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Long receiver hold-off while the sender keeps offering items.
		fork
			begin
				recv_hold = 1'b1;
				for (k = 0; k < 200; k++) @(posedge clk);
				recv_hold = 1'b0;
			end
			random_phase(N_RANDOM / 3);
		join
		drain();

		$display("covered %0d checked track items over 8 register settings,",
			checked_count);
		$display("with bound scaling, dead zones, reverse gain and back-pressure stalls");
		if (err_count == 0) begin
			$display("tb_tank_drive_mixer_top: clean");
		end else begin
			$display("tb_tank_drive_mixer_top: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tdm_pkg.sv
rtl/tdm_if.sv
rtl/tdm_cfg.sv
rtl/tdm_qdiv.sv
rtl/tank_drive_mixer_top.sv
dv/tb_tank_drive_mixer_top.sv
